### src/first_fit_coalescing_allocator_defines.svh
// assertion macros for the first-fit coalescing allocator
`ifndef FIRST_FIT_COALESCING_ALLOCATOR_DEFINES_SVH
`define FIRST_FIT_COALESCING_ALLOCATOR_DEFINES_SVH

// property checked at every clock edge outside reset
`define FFCA_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// antecedent implies consequent in the next cycle
`define FFCA_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) else $error(msg);

`endif

### src/ffca_pkg.sv
// shared types and constants of the first-fit coalescing allocator
package ffca_pkg;

   localparam int FFCA_MAX_LIVE_BLOCKS  = 16;
   localparam int FFCA_MAX_FREE_EXTENTS = 17;
   localparam int FFCA_ADDR_BITS        = 32;

   localparam int FIELD_W     = 32;
   localparam int CSR_INDEX_W = 2;
   localparam int ALIGN_W     = 4;

   localparam logic [FIELD_W-1:0] CAPACITY_RESET  = 32'd65536;
   localparam logic [ALIGN_W-1:0] ALIGNMENT_RESET = 4'd8;
   localparam logic [ALIGN_W-1:0] ALIGNMENT_MAX   = 4'd12;

   localparam logic [CSR_INDEX_W-1:0] REG_CAPACITY  = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_ALIGNMENT = 2'd1;

   localparam logic OP_ALLOC = 1'b0;
   localparam logic OP_FREE  = 1'b1;

   localparam logic [1:0] ST_OK       = 2'd0;
   localparam logic [1:0] ST_NO_FIT   = 2'd1;
   localparam logic [1:0] ST_NOT_LIVE = 2'd2;
   localparam logic [1:0] ST_FULL     = 2'd3;

   typedef struct packed {
      logic               opcode;
      logic [FIELD_W-1:0] request_size;
      logic [FIELD_W-1:0] block_offset;
   } req_type;

   typedef struct packed {
      logic [1:0]         status;
      logic [FIELD_W-1:0] granted_offset;
      logic [FIELD_W-1:0] granted_size;
      logic [FIELD_W-1:0] total_free;
      logic [FIELD_W-1:0] largest_free;
   } rsp_type;

endpackage

### src/ffca_ram.sv
// generic single-write, single-read ram with registered read data
module ffca_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

### src/first_fit_coalescing_allocator.sv
// first-fit allocator top level: sequencer over free-extent and live-block rams
// each ram entry visited takes a read phase and then a phase that uses the data,
// since each ram has one registered read port
// one request at a time; the next is taken the cycle after the result is loaded
// synchronous reset, then the init state writes the first extent (also after capacity or alignment writes)
`include "first_fit_coalescing_allocator_defines.svh"
module first_fit_coalescing_allocator #(
   parameter int MAX_LIVE_BLOCKS  = ffca_pkg::FFCA_MAX_LIVE_BLOCKS,
   parameter int MAX_FREE_EXTENTS = ffca_pkg::FFCA_MAX_FREE_EXTENTS,
   parameter int ADDR_BITS        = ffca_pkg::FFCA_ADDR_BITS
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  ffca_pkg::req_type                    req_data,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output ffca_pkg::rsp_type                    rsp_data,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [ffca_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [ffca_pkg::FIELD_W-1:0]         csr_wdata
);
   import ffca_pkg::*;

   localparam int ML  = MAX_LIVE_BLOCKS;
   localparam int MF  = MAX_FREE_EXTENTS;
   localparam int AW  = ADDR_BITS;
   localparam int VW  = ((AW > 33) ? AW : 33) + 1;
   localparam int LIW = $clog2(ML);
   localparam int LCW = $clog2(ML + 1);
   localparam int FIW = $clog2(MF);
   localparam int CW  = $clog2(MF + 1);
   localparam int NW  = VW;

   localparam logic [3:0] S_INIT  = 4'd0;
   localparam logic [3:0] S_IDLE  = 4'd1;
   localparam logic [3:0] S_SLOT  = 4'd2;
   localparam logic [3:0] S_FIT   = 4'd3;
   localparam logic [3:0] S_RMV   = 4'd4;
   localparam logic [3:0] S_LFIND = 4'd5;
   localparam logic [3:0] S_POS   = 4'd6;
   localparam logic [3:0] S_DEC   = 4'd7;
   localparam logic [3:0] S_INS   = 4'd8;
   localparam logic [3:0] S_SUM   = 4'd9;
   localparam logic [3:0] S_DONE  = 4'd10;

   logic [3:0]         state_ff, state_in;
   logic [FIELD_W-1:0] cap_ff, cap_in;
   logic [ALIGN_W-1:0] align_ff, align_in;
   logic [CW-1:0]      nfree_ff, nfree_in;
   logic [ML-1:0]      lvalid_ff, lvalid_in;
   logic [CW-1:0]      k_ff, k_in;
   logic [CW-1:0]      idx_ff, idx_in;
   logic [LCW-1:0]     li_ff, li_in;
   logic               ph_ff, ph_in;
   logic [NW-1:0]      need_ff, need_in;
   logic [FIELD_W-1:0] bo_ff, bo_in;
   logic [AW-1:0]      off_ff, off_in;
   logic [AW-1:0]      sz_ff, sz_in;
   logic [AW-1:0]      prv_start_ff, prv_start_in;
   logic [AW-1:0]      prv_len_ff, prv_len_in;
   logic [AW-1:0]      nxt_start_ff, nxt_start_in;
   logic [AW-1:0]      nxt_len_ff, nxt_len_in;
   logic               has_nxt_ff, has_nxt_in;
   logic [1:0]         status_ff, status_in;
   logic [AW-1:0]      tot_ff, tot_in;
   logic [AW-1:0]      big_ff, big_in;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_type            rsp_data_ff, rsp_data_in;

   logic               fw_en;
   logic [FIW-1:0]     fw_addr;
   logic [2*AW-1:0]    fw_data;
   logic [FIW-1:0]     fr_addr;
   logic [2*AW-1:0]    frd;
   logic               lw_en;
   logic [2*AW-1:0]    lw_data;
   logic [2*AW-1:0]    lrd;

   logic [AW-1:0]      rd_start, rd_len, lrd_start, lrd_len;
   logic [ALIGN_W-1:0] lg;
   logic [VW-1:0]      umask_v, cap_v, rs_v, need_v;
   logic [AW-1:0]      cap_use, need_a;
   logic [CW-1:0]      kp1, km1;
   logic               nt, pt;
   logic               req_xfer, csr_xfer;
   logic [VW-1:0]      goff_v, gsize_v, tot_v, big_v;

   assign rd_start  = frd[2*AW-1:AW];
   assign rd_len    = frd[AW-1:0];
   assign lrd_start = lrd[2*AW-1:AW];
   assign lrd_len   = lrd[AW-1:0];

   assign lg      = (align_ff > ALIGNMENT_MAX) ? ALIGNMENT_MAX : align_ff;
   assign umask_v = (VW'(1) << lg) - VW'(1);
   assign cap_v   = VW'(cap_ff) & ~umask_v;
   assign cap_use = cap_v[AW-1:0];
   assign rs_v    = (req_data.request_size == '0) ? VW'(1) : VW'(req_data.request_size);
   assign need_v  = (rs_v + umask_v) & ~umask_v;
   assign need_a  = need_ff[AW-1:0];
   assign kp1     = k_ff + CW'(1);
   assign km1     = k_ff - CW'(1);

   assign nt = has_nxt_ff && ((VW'(off_ff) + VW'(sz_ff)) == VW'(nxt_start_ff));
   assign pt = (k_ff != '0) && ((VW'(prv_start_ff) + VW'(prv_len_ff)) == VW'(off_ff));

   assign req_stall = (state_ff != S_IDLE);
   assign csr_ready = (state_ff == S_IDLE);
   assign req_xfer  = req_valid && !req_stall;
   assign csr_xfer  = csr_valid && csr_ready;

   assign goff_v  = (status_ff == ST_OK) ? VW'(off_ff) : '0;
   assign gsize_v = (status_ff == ST_OK) ? VW'(sz_ff) : '0;
   assign tot_v   = VW'(tot_ff);
   assign big_v   = VW'(big_ff);

   always_comb begin
      case (state_ff)
         S_RMV:   fr_addr = kp1[FIW-1:0];
         S_INS:   fr_addr = km1[FIW-1:0];
         default: fr_addr = k_ff[FIW-1:0];
      endcase
   end

   always_comb begin
      state_in     = state_ff;
      cap_in       = cap_ff;
      align_in     = align_ff;
      nfree_in     = nfree_ff;
      lvalid_in    = lvalid_ff;
      k_in         = k_ff;
      idx_in       = idx_ff;
      li_in        = li_ff;
      ph_in        = ph_ff;
      need_in      = need_ff;
      bo_in        = bo_ff;
      off_in       = off_ff;
      sz_in        = sz_ff;
      prv_start_in = prv_start_ff;
      prv_len_in   = prv_len_ff;
      nxt_start_in = nxt_start_ff;
      nxt_len_in   = nxt_len_ff;
      has_nxt_in   = has_nxt_ff;
      status_in    = status_ff;
      tot_in       = tot_ff;
      big_in       = big_ff;
      rsp_valid_in = (rsp_valid_ff && !rsp_stall) ? 1'b0 : rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      fw_en        = 1'b0;
      fw_addr      = k_ff[FIW-1:0];
      fw_data      = frd;
      lw_en        = 1'b0;
      lw_data      = {off_ff, sz_ff};

      case (state_ff)
         S_INIT: begin
            fw_en    = 1'b1;
            fw_addr  = '0;
            fw_data  = {{AW{1'b0}}, cap_use};
            nfree_in = (cap_use != '0) ? CW'(1) : '0;
            state_in = S_IDLE;
         end
         S_IDLE: begin
            if (csr_xfer) begin
               if (csr_index == REG_CAPACITY) begin
                  cap_in = csr_wdata;
               end
               if (csr_index == REG_ALIGNMENT) begin
                  align_in = csr_wdata[ALIGN_W-1:0];
               end
               if (csr_index == REG_CAPACITY || csr_index == REG_ALIGNMENT) begin
                  lvalid_in = '0;
                  state_in  = S_INIT;
               end
            end else if (req_xfer) begin
               need_in  = need_v[NW-1:0];
               bo_in    = req_data.block_offset;
               li_in    = '0;
               ph_in    = 1'b0;
               state_in = (req_data.opcode == OP_ALLOC) ? S_SLOT : S_LFIND;
            end
         end
         S_SLOT: begin
            if (li_ff == LCW'(ML)) begin
               status_in = ST_FULL;
               state_in  = S_SUM;
               k_in      = '0;
               ph_in     = 1'b0;
               tot_in    = '0;
               big_in    = '0;
            end else if (!lvalid_ff[li_ff[LIW-1:0]]) begin
               k_in     = '0;
               ph_in    = 1'b0;
               state_in = S_FIT;
            end else begin
               li_in = li_ff + LCW'(1);
            end
         end
         S_FIT: begin
            if (k_ff >= nfree_ff) begin
               status_in = ST_NO_FIT;
               state_in  = S_SUM;
               k_in      = '0;
               ph_in     = 1'b0;
               tot_in    = '0;
               big_in    = '0;
            end else if (!ph_ff) begin
               ph_in = 1'b1;
            end else if (VW'(rd_len) >= VW'(need_ff)) begin
               off_in    = rd_start;
               sz_in     = need_a;
               status_in = ST_OK;
               lw_en     = 1'b1;
               lw_data   = {rd_start, need_a};
               lvalid_in[li_ff[LIW-1:0]] = 1'b1;
               ph_in     = 1'b0;
               if (rd_len != need_a) begin
                  fw_en    = 1'b1;
                  fw_data  = {rd_start + need_a, rd_len - need_a};
                  state_in = S_SUM;
                  k_in     = '0;
                  tot_in   = '0;
                  big_in   = '0;
               end else begin
                  state_in = S_RMV;
               end
            end else begin
               k_in  = kp1;
               ph_in = 1'b0;
            end
         end
         S_RMV: begin
            if (kp1 >= nfree_ff) begin
               nfree_in = nfree_ff - CW'(1);
               state_in = S_SUM;
               k_in     = '0;
               ph_in    = 1'b0;
               tot_in   = '0;
               big_in   = '0;
            end else if (!ph_ff) begin
               ph_in = 1'b1;
            end else begin
               fw_en = 1'b1;
               k_in  = kp1;
               ph_in = 1'b0;
            end
         end
         S_LFIND: begin
            if (li_ff == LCW'(ML)) begin
               status_in = ST_NOT_LIVE;
               state_in  = S_SUM;
               k_in      = '0;
               ph_in     = 1'b0;
               tot_in    = '0;
               big_in    = '0;
            end else if (!lvalid_ff[li_ff[LIW-1:0]]) begin
               li_in = li_ff + LCW'(1);
            end else if (!ph_ff) begin
               ph_in = 1'b1;
            end else if (VW'(lrd_start) == VW'(bo_ff)) begin
               off_in     = lrd_start;
               sz_in      = lrd_len;
               k_in       = '0;
               ph_in      = 1'b0;
               has_nxt_in = 1'b0;
               state_in   = S_POS;
            end else begin
               li_in = li_ff + LCW'(1);
               ph_in = 1'b0;
            end
         end
         S_POS: begin
            if (k_ff >= nfree_ff) begin
               has_nxt_in = 1'b0;
               state_in   = S_DEC;
            end else if (!ph_ff) begin
               ph_in = 1'b1;
            end else if (rd_start < off_ff) begin
               prv_start_in = rd_start;
               prv_len_in   = rd_len;
               k_in         = kp1;
               ph_in        = 1'b0;
            end else begin
               nxt_start_in = rd_start;
               nxt_len_in   = rd_len;
               has_nxt_in   = 1'b1;
               ph_in        = 1'b0;
               state_in     = S_DEC;
            end
         end
         S_DEC: begin
            ph_in  = 1'b0;
            idx_in = k_ff;
            if (!nt && !pt && nfree_ff >= CW'(MF)) begin
               status_in = ST_FULL;
               state_in  = S_SUM;
               k_in      = '0;
               tot_in    = '0;
               big_in    = '0;
            end else begin
               status_in = ST_OK;
               lvalid_in[li_ff[LIW-1:0]] = 1'b0;
               if (pt && nt) begin
                  fw_en    = 1'b1;
                  fw_addr  = km1[FIW-1:0];
                  fw_data  = {prv_start_ff, prv_len_ff + sz_ff + nxt_len_ff};
                  state_in = S_RMV;
               end else if (pt) begin
                  fw_en    = 1'b1;
                  fw_addr  = km1[FIW-1:0];
                  fw_data  = {prv_start_ff, prv_len_ff + sz_ff};
                  state_in = S_SUM;
                  k_in     = '0;
                  tot_in   = '0;
                  big_in   = '0;
               end else if (nt) begin
                  fw_en    = 1'b1;
                  fw_data  = {off_ff, sz_ff + nxt_len_ff};
                  state_in = S_SUM;
                  k_in     = '0;
                  tot_in   = '0;
                  big_in   = '0;
               end else begin
                  k_in     = nfree_ff;
                  state_in = S_INS;
               end
            end
         end
         S_INS: begin
            if (k_ff == idx_ff) begin
               fw_en    = 1'b1;
               fw_data  = {off_ff, sz_ff};
               nfree_in = nfree_ff + CW'(1);
               state_in = S_SUM;
               k_in     = '0;
               ph_in    = 1'b0;
               tot_in   = '0;
               big_in   = '0;
            end else if (!ph_ff) begin
               ph_in = 1'b1;
            end else begin
               fw_en = 1'b1;
               k_in  = km1;
               ph_in = 1'b0;
            end
         end
         S_SUM: begin
            if (k_ff >= nfree_ff) begin
               state_in = S_DONE;
            end else if (!ph_ff) begin
               ph_in = 1'b1;
            end else begin
               tot_in = tot_ff + rd_len;
               big_in = (rd_len > big_ff) ? rd_len : big_ff;
               k_in   = kp1;
               ph_in  = 1'b0;
            end
         end
         S_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in               = 1'b1;
               rsp_data_in.status         = status_ff;
               rsp_data_in.granted_offset = goff_v[FIELD_W-1:0];
               rsp_data_in.granted_size   = gsize_v[FIELD_W-1:0];
               rsp_data_in.total_free     = tot_v[FIELD_W-1:0];
               rsp_data_in.largest_free   = big_v[FIELD_W-1:0];
               state_in                   = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_INIT;
         cap_ff       <= CAPACITY_RESET;
         align_ff     <= ALIGNMENT_RESET;
         nfree_ff     <= '0;
         lvalid_ff    <= '0;
         ph_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cap_ff       <= cap_in;
         align_ff     <= align_in;
         nfree_ff     <= nfree_in;
         lvalid_ff    <= lvalid_in;
         ph_ff        <= ph_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      k_ff         <= k_in;
      idx_ff       <= idx_in;
      li_ff        <= li_in;
      need_ff      <= need_in;
      bo_ff        <= bo_in;
      off_ff       <= off_in;
      sz_ff        <= sz_in;
      prv_start_ff <= prv_start_in;
      prv_len_ff   <= prv_len_in;
      nxt_start_ff <= nxt_start_in;
      nxt_len_ff   <= nxt_len_in;
      has_nxt_ff   <= has_nxt_in;
      status_ff    <= status_in;
      tot_ff       <= tot_in;
      big_ff       <= big_in;
      rsp_data_ff  <= rsp_data_in;
   end

   ffca_ram #(
      .WIDTH (2 * AW),
      .DEPTH (MF)
   ) u_free_ram (
      .clock   (clock),
      .wr_en   (fw_en),
      .wr_addr (fw_addr),
      .wr_data (fw_data),
      .rd_addr (fr_addr),
      .rd_data (frd)
   );

   ffca_ram #(
      .WIDTH (2 * AW),
      .DEPTH (ML)
   ) u_live_ram (
      .clock   (clock),
      .wr_en   (lw_en),
      .wr_addr (li_ff[LIW-1:0]),
      .wr_data (lw_data),
      .rd_addr (li_ff[LIW-1:0]),
      .rd_data (lrd)
   );

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   `FFCA_ASSERT(a_nfree_bound, nfree_ff <= CW'(MF), "free extent count above table depth")
   `FFCA_ASSERT(a_rsp_from_done, $rose(rsp_valid_ff) |-> $past(state_ff) == S_DONE, "result without done")
   `FFCA_ASSERT_NEXT(a_csr_reinit, csr_xfer && (csr_index == REG_CAPACITY || csr_index == REG_ALIGNMENT), state_ff == S_INIT, "register write did not reinit pool")
endmodule

### tb/tb.sv
// self-checking testbench for the first-fit coalescing allocator
`timescale 1ns / 1ps
module tb;
   import ffca_pkg::*;

   localparam logic [CSR_INDEX_W-1:0] REG_UNUSED = 2'd2;
   localparam int NL = FFCA_MAX_LIVE_BLOCKS;
   localparam int NF = FFCA_MAX_FREE_EXTENTS;
   localparam int CYCLE_LIMIT = 3000000;

   typedef struct {
      logic    op;
      logic [31:0] size;
      logic [31:0] offs;
      int      rep;
      bit      typed;
      rsp_type want;
   } dir_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   req_type req_data = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   rsp_type rsp_data;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [FIELD_W-1:0] csr_wdata = '0;

   // mirror of the allocator state
   logic [31:0] cap_reg;
   logic [3:0]  align_reg;
   longint unsigned ext_start [NF];
   longint unsigned ext_len [NF];
   bit              ext_vld [NF];
   longint unsigned blk_start [NL];
   longint unsigned blk_len [NL];
   bit              blk_vld [NL];

   rsp_type grant_q[$];
   int err_cnt = 0;
   int idle_pct = 0;
   int stall_pct = 0;
   bit hold_req = 0;
   int hold_left = 0;
   longint cycles = 0;
   dir_row_type dir_tab[16];

   first_fit_coalescing_allocator i_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   function automatic longint unsigned unit_bytes();
      return 64'd1 << ((align_reg > ALIGNMENT_MAX) ? ALIGNMENT_MAX : align_reg);
   endfunction

   function automatic longint unsigned usable_cap();
      return {32'd0, cap_reg} & ~(unit_bytes() - 1);
   endfunction

   function automatic void pool_clear();
      for (int i = 0; i < NF; i++) begin
         ext_start[i] = 0; ext_len[i] = 0; ext_vld[i] = 0;
      end
      for (int i = 0; i < NL; i++) begin
         blk_start[i] = 0; blk_len[i] = 0; blk_vld[i] = 0;
      end
      if (usable_cap() != 0) begin
         ext_len[0] = usable_cap();
         ext_vld[0] = 1;
      end
   endfunction

   function automatic int ext_count();
      int n = 0;
      while (n < NF && ext_vld[n]) n++;
      return n;
   endfunction

   function automatic void ext_remove(int at, int n);
      for (int k = at; k + 1 < n; k++) begin
         ext_start[k] = ext_start[k+1];
         ext_len[k] = ext_len[k+1];
      end
      if (n > 0) begin
         ext_vld[n-1] = 0; ext_start[n-1] = 0; ext_len[n-1] = 0;
      end
   endfunction

   function automatic void ext_insert(int at, int n, longint unsigned s, longint unsigned l);
      if (n >= NF) return;
      for (int k = n; k > at; k--) begin
         ext_start[k] = ext_start[k-1];
         ext_len[k] = ext_len[k-1];
      end
      ext_start[at] = s;
      ext_len[at] = l;
      ext_vld[n] = 1;
   endfunction

   // applies one request to the mirror and returns the grant it yields
   function automatic rsp_type predict_grant(req_type r);
      rsp_type o;
      longint unsigned u, rs, need, off, sz, merged, tot, big;
      int n, slot, hit, j, idx;
      bit mn, mp;
      o = '0;
      n = ext_count();
      slot = -1; hit = -1; j = -1; tot = 0; big = 0;
      if (r.opcode == OP_ALLOC) begin
         u = unit_bytes();
         rs = (r.request_size == 0) ? 1 : r.request_size;
         need = (rs + u - 1) & ~(u - 1);
         for (int i = 0; i < NL && slot < 0; i++) if (!blk_vld[i]) slot = i;
         if (slot < 0) begin
            o.status = ST_FULL;
         end else begin
            for (int i = 0; i < n && hit < 0; i++) if (ext_len[i] >= need) hit = i;
            if (hit < 0) begin
               o.status = ST_NO_FIT;
            end else begin
               off = ext_start[hit];
               if (ext_len[hit] > need) begin
                  ext_start[hit] = off + need;
                  ext_len[hit] = ext_len[hit] - need;
               end else begin
                  ext_remove(hit, n);
               end
               blk_start[slot] = off; blk_len[slot] = need; blk_vld[slot] = 1;
               o.status = ST_OK;
               o.granted_offset = off[31:0];
               o.granted_size = need[31:0];
            end
         end
      end else begin
         for (int i = 0; i < NL && j < 0; i++)
            if (blk_vld[i] && blk_start[i] == r.block_offset) j = i;
         if (j < 0) begin
            o.status = ST_NOT_LIVE;
         end else begin
            off = blk_start[j];
            sz = blk_len[j];
            idx = 0;
            while (idx < n && ext_start[idx] < off) idx++;
            mn = idx < n && off + sz == ext_start[idx];
            mp = idx > 0 && ext_start[idx-1] + ext_len[idx-1] == off;
            if (!mn && !mp && n >= NF) begin
               o.status = ST_FULL;
            end else begin
               merged = sz;
               blk_vld[j] = 0;
               if (mn) begin
                  merged += ext_len[idx];
                  ext_remove(idx, n);
                  n--;
               end
               if (mp) ext_len[idx-1] += merged;
               else ext_insert(idx, n, off, merged);
               o.status = ST_OK;
               o.granted_offset = off[31:0];
               o.granted_size = sz[31:0];
            end
         end
      end
      n = ext_count();
      for (int i = 0; i < n; i++) begin
         tot += ext_len[i];
         if (ext_len[i] > big) big = ext_len[i];
      end
      o.total_free = tot[31:0];
      o.largest_free = big[31:0];
      return o;
   endfunction

   function automatic req_type random_req();
      req_type r;
      int lives[$];
      longint unsigned top;
      int pick;
      for (int i = 0; i < NL; i++) if (blk_vld[i]) lives.push_back(i);
      r.request_size = $urandom;
      r.block_offset = $urandom;
      pick = $urandom_range(99);
      if ((lives.size() == NL && pick < 70) || (lives.size() > 0 && pick < 35)) begin
         r.opcode = OP_FREE;
         if ($urandom_range(9) < 8)
            r.block_offset = blk_start[lives[$urandom_range(lives.size() - 1)]][31:0];
         else if ($urandom_range(1) == 0)
            r.block_offset = 32'(blk_start[lives[0]] + 1);
      end else if (pick < 40) begin
         r.opcode = OP_FREE;
      end else begin
         r.opcode = OP_ALLOC;
         pick = $urandom_range(99);
         top = usable_cap() / 8;
         if (top < 1) top = 1;
         if (top > 32'hFFFF_FFFF) top = 32'hFFFF_FFFF;
         if (pick < 10) r.request_size = 0;
         else if (pick < 14) r.request_size = 32'hFFFF_FFFF;
         else if (pick >= 20) r.request_size = $urandom_range(top[31:0], 1);
      end
      return r;
   endfunction

   task automatic send_req(req_type r);
      req_data <= r;
      req_valid <= 1'b1;
      do @(posedge clock); while (req_stall);
      grant_q.push_back(predict_grant(r));
      while ($urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      while (grant_q.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
   endtask

   task automatic write_reg(logic [CSR_INDEX_W-1:0] idx, logic [31:0] val);
      wait_drained();
      csr_index <= idx;
      csr_wdata <= val;
      csr_valid <= 1'b1;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      if (idx == REG_CAPACITY) begin
         cap_reg = val;
         pool_clear();
      end else if (idx == REG_ALIGNMENT) begin
         align_reg = val[3:0];
         pool_clear();
      end
   endtask

   task automatic run_random(int count, int mode, bit long_hold, bit mid_drain);
      idle_pct = (mode == 1 || mode == 3) ? ((mode == 1) ? 73 : 28) : 0;
      stall_pct = (mode == 2 || mode == 3) ? ((mode == 2) ? 73 : 28) : 0;
      for (int k = 0; k < count; k++) begin
         if (long_hold && k == 10) hold_req = 1;
         if (mid_drain && k == count / 2) begin
            req_valid <= 1'b0;
            while (grant_q.size() != 0) @(posedge clock);
         end
         send_req(random_req());
      end
   endtask

   task automatic check_grant(rsp_type got);
      rsp_type w;
      if (grant_q.size() == 0) begin
         $error("unexpected transfer on the result channel");
         err_cnt++;
         return;
      end
      w = grant_q.pop_front();
      if (got.status !== w.status) begin
         $error("status exp %0d got %0d", w.status, got.status); err_cnt++;
      end
      if (got.granted_offset !== w.granted_offset) begin
         $error("granted_offset exp %0h got %0h", w.granted_offset, got.granted_offset);
         err_cnt++;
      end
      if (got.granted_size !== w.granted_size) begin
         $error("granted_size exp %0h got %0h", w.granted_size, got.granted_size); err_cnt++;
      end
      if (got.total_free !== w.total_free) begin
         $error("total_free exp %0h got %0h", w.total_free, got.total_free); err_cnt++;
      end
      if (got.largest_free !== w.largest_free) begin
         $error("largest_free exp %0h got %0h", w.largest_free, got.largest_free); err_cnt++;
      end
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) check_grant(rsp_data);
      if (hold_req) begin
         hold_left = 400;
         hold_req = 0;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < stall_pct);
      end
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   initial begin
      req_type r;
      rsp_type p;
      dir_tab = '{
         '{OP_ALLOC, 32'd0, 32'hFFFF_FFFF, 1, 1, '{ST_OK, 0, 256, 65280, 65280}},
         '{OP_ALLOC, 32'd1, 32'd0, 1, 1, '{ST_OK, 256, 256, 65024, 65024}},
         '{OP_ALLOC, 32'hFFFF_FFFF, 32'd0, 1, 1, '{ST_NO_FIT, 0, 0, 65024, 65024}},
         '{OP_FREE, 32'hFFFF_FFFF, 32'h1_2345, 1, 1, '{ST_NOT_LIVE, 0, 0, 65024, 65024}},
         '{OP_FREE, 32'd0, 32'd0, 1, 1, '{ST_OK, 0, 256, 65280, 65024}},
         '{OP_FREE, 32'd0, 32'd256, 1, 1, '{ST_OK, 256, 256, 65536, 65536}},
         '{OP_ALLOC, 32'd65536, 32'd0, 1, 1, '{ST_OK, 0, 65536, 0, 0}},
         '{OP_ALLOC, 32'd1, 32'd0, 1, 1, '{ST_NO_FIT, 0, 0, 0, 0}},
         '{OP_FREE, 32'd0, 32'd0, 1, 1, '{ST_OK, 0, 65536, 65536, 65536}},
         '{OP_ALLOC, 32'd257, 32'd0, 1, 0, '0},
         '{OP_ALLOC, 32'd256, 32'd0, 16, 0, '0},
         '{OP_ALLOC, 32'hFFFF_FFFF, 32'd0, 1, 1, '{ST_FULL, 0, 0, 61184, 61184}},
         '{OP_FREE, 32'd0, 32'd1, 1, 0, '0},
         '{OP_FREE, 32'd0, 32'd512, 1, 0, '0},
         '{OP_FREE, 32'd0, 32'd1024, 1, 0, '0},
         '{OP_FREE, 32'd0, 32'd768, 1, 0, '0}
      };
      cap_reg = CAPACITY_RESET;
      align_reg = ALIGNMENT_RESET;
      pool_clear();
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      foreach (dir_tab[i]) begin
         for (int k = 0; k < dir_tab[i].rep; k++) begin
            r.opcode = dir_tab[i].op;
            r.request_size = dir_tab[i].size;
            r.block_offset = dir_tab[i].offs;
            req_data <= r;
            req_valid <= 1'b1;
            do @(posedge clock); while (req_stall);
            p = predict_grant(r);
            grant_q.push_back(dir_tab[i].typed ? dir_tab[i].want : p);
         end
      end
      run_random(150, 0, 0, 0);

      write_reg(REG_CAPACITY, 32'd4096);
      write_reg(REG_ALIGNMENT, 4'd4);
      run_random(150, 1, 0, 0);

      write_reg(REG_ALIGNMENT, ALIGNMENT_MAX);
      write_reg(REG_CAPACITY, 32'hFFFF_FFFF);
      run_random(150, 2, 1, 0);

      write_reg(REG_ALIGNMENT, 4'd0);
      write_reg(REG_CAPACITY, 32'd1000);
      run_random(150, 3, 0, 1);

      write_reg(REG_UNUSED, $urandom);
      write_reg(REG_ALIGNMENT, 4'd15);
      write_reg(REG_CAPACITY, 32'd5000);
      run_random(100, 0, 0, 0);

      write_reg(REG_CAPACITY, 32'd1);
      run_random(15, 1, 0, 0);
      write_reg(REG_ALIGNMENT, 4'd0);
      run_random(15, 3, 0, 0);

      wait_drained();
      repeat (150) @(posedge clock);
      if (grant_q.size() != 0) begin
         $error("results still outstanding: %0d", grant_q.size());
         err_cnt++;
      end
      if (err_cnt == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end
endmodule

### first_fit_coalescing_allocator.f
+incdir+src
src/ffca_pkg.sv
src/ffca_ram.sv
src/first_fit_coalescing_allocator.sv
tb/tb.sv
